/* rtl/core/slm_pkg.sv */
// Shared types and constants for the sorted list merge block.
package slm_pkg;

    localparam int ELEM_W      = 32;
    localparam int QUEUE_DEPTH = 4;

    // Input mode codes as they arrive on the item channel.
    typedef enum logic [1:0] {
        MODE_APPEND_FIRST  = 2'd0,
        MODE_APPEND_SECOND = 2'd1,
        MODE_MERGE         = 2'd2,
        MODE_UNUSED        = 2'd3
    } mode_t;

    // Commands handed from the front stage to the back end.
    typedef enum logic [1:0] {
        CMD_APPEND_FIRST  = 2'd0,
        CMD_APPEND_SECOND = 2'd1,
        CMD_MERGE         = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic signed [ELEM_W-1:0]  element;
    } cmd_t;

    // Handshake between the queue and the back end.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

    typedef enum logic {
        BK_IDLE  = 1'b0,
        BK_MERGE = 1'b1
    } back_state_t;

endpackage

/* rtl/core/slm_front.sv */
// Front stage: takes input transfers, drops unused modes, registers the command.
module slm_front
    import slm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [1:0]               mode,
    input  logic signed [ELEM_W-1:0] element,
    output logic                     cmd_valid,
    output cmd_t                     cmd,
    input  logic                     cmd_full
);

    logic      stage_valid_reg;
    logic      stage_valid_next;
    cmd_t      stage_cmd_reg;
    cmd_kind_t kind;
    logic      keep;
    logic      load;

    always_comb
    begin
        kind = CMD_APPEND_FIRST;
        keep = 1'b1;
        unique case (mode_t'(mode))
            MODE_APPEND_FIRST:  kind = CMD_APPEND_FIRST;
            MODE_APPEND_SECOND: kind = CMD_APPEND_SECOND;
            MODE_MERGE:         kind = CMD_MERGE;
            default:            keep = 1'b0;
        endcase
    end

    assign item_stall = stage_valid_reg && cmd_full;
    assign load       = !stage_valid_reg || !cmd_full;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (load)
        begin
            stage_valid_next = item_valid && keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && item_valid && keep)
        begin
            stage_cmd_reg.kind    <= kind;
            stage_cmd_reg.element <= element;
        end
    end

    assign cmd_valid = stage_valid_reg;
    assign cmd       = stage_cmd_reg;

endmodule

/* rtl/core/slm_queue.sv */
// Short command queue between the front stage and the back end.
module slm_queue
    import slm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  cmd_t      push_cmd,
    output logic      full,
    input  logic      pop,
    output cmd_head_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;

    assign full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push = push_valid && !full;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = entries[rd_ptr_reg];

endmodule

/* rtl/core/slm_back.sv */
// Back end: list stores, appends and the merge sequencer with its output register.
module slm_back
    import slm_pkg::*;
#(
    parameter int LIST_DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_head_t                head,
    output logic                     pop,
    input  logic                     result_stall,
    output logic                     result_valid,
    output logic signed [ELEM_W-1:0] merged_value,
    output logic                     last_of_run,
    output logic                     descending_order,
    output logic                     overflow_seen,
    output logic                     busy
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    logic signed [ELEM_W-1:0] first_mem  [LIST_DEPTH];
    logic signed [ELEM_W-1:0] second_mem [LIST_DEPTH];

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [CNT_W-1:0]         first_count_reg;
    logic [CNT_W-1:0]         second_count_reg;
    logic                     dropped_reg;
    logic signed [ELEM_W-1:0] first_head_reg;
    logic signed [ELEM_W-1:0] first_tail_reg;
    logic [CNT_W-1:0]         i_reg;
    logic [CNT_W-1:0]         i_next;
    logic [CNT_W-1:0]         j_reg;
    logic [CNT_W-1:0]         j_next;
    logic signed [ELEM_W-1:0] a_data_reg;
    logic signed [ELEM_W-1:0] b_data_reg;
    logic                     desc_reg;
    logic                     ovf_reg;
    logic                     result_valid_reg;
    logic                     result_valid_next;
    logic signed [ELEM_W-1:0] merged_value_reg;
    logic                     last_reg;
    logic                     desc_out_reg;
    logic                     ovf_out_reg;

    logic do_append_first;
    logic do_append_second;
    logic do_merge;
    logic merge_empty;
    logic emit;
    logic a_avail;
    logic b_avail;
    logic take_first;
    logic is_last;
    logic first_full;
    logic second_full;

    // Control outputs.
    always_comb
    begin
        pop              = (state_reg == BK_IDLE) && head.valid;
        emit             = (state_reg == BK_MERGE) && (!result_valid_reg || !result_stall);
        do_append_first  = pop && (head.cmd.kind == CMD_APPEND_FIRST);
        do_append_second = pop && (head.cmd.kind == CMD_APPEND_SECOND);
        do_merge         = pop && (head.cmd.kind == CMD_MERGE);
    end

    assign merge_empty = (first_count_reg == '0) && (second_count_reg == '0);
    assign first_full  = (first_count_reg == CNT_W'(LIST_DEPTH));
    assign second_full = (second_count_reg == CNT_W'(LIST_DEPTH));

    // Head selection; a tie always goes to the first list.
    always_comb
    begin
        a_avail = (i_reg < first_count_reg);
        b_avail = (j_reg < second_count_reg);
        if (a_avail && b_avail)
        begin
            take_first = desc_reg ? (a_data_reg >= b_data_reg) : (a_data_reg <= b_data_reg);
        end
        else
        begin
            take_first = a_avail;
        end
        if (take_first)
        begin
            is_last = (CNT_W'(i_reg + 1'b1) == first_count_reg) && !b_avail;
        end
        else
        begin
            is_last = (CNT_W'(j_reg + 1'b1) == second_count_reg) && !a_avail;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (do_merge && !merge_empty)
                begin
                    state_next = BK_MERGE;
                end
            end
            BK_MERGE:
            begin
                if (emit && is_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Read indexes; the stores are read at the next index so the data is ready.
    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        if (state_reg == BK_IDLE || (emit && is_last))
        begin
            i_next = '0;
            j_next = '0;
        end
        else if (emit)
        begin
            if (take_first)
            begin
                i_next = i_reg + 1'b1;
            end
            else
            begin
                j_next = j_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            dropped_reg      <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            result_valid_reg <= result_valid_next;
            if (do_append_first)
            begin
                if (first_full)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    first_count_reg <= first_count_reg + 1'b1;
                end
            end
            if (do_append_second)
            begin
                if (second_full)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    second_count_reg <= second_count_reg + 1'b1;
                end
            end
            if ((do_merge && merge_empty) || (emit && is_last))
            begin
                first_count_reg  <= '0;
                second_count_reg <= '0;
                dropped_reg      <= 1'b0;
            end
        end
    end

    // Stores and payload registers.
    always_ff @(posedge clk)
    begin
        if (do_append_first && !first_full)
        begin
            first_mem[first_count_reg[IDX_W-1:0]] <= head.cmd.element;
            first_tail_reg                        <= head.cmd.element;
            if (first_count_reg == '0)
            begin
                first_head_reg <= head.cmd.element;
            end
        end
        if (do_append_second && !second_full)
        begin
            second_mem[second_count_reg[IDX_W-1:0]] <= head.cmd.element;
        end
        a_data_reg <= first_mem[i_next[IDX_W-1:0]];
        b_data_reg <= second_mem[j_next[IDX_W-1:0]];
        if (do_merge)
        begin
            desc_reg <= (first_count_reg != '0) && !(first_head_reg < first_tail_reg);
            ovf_reg  <= dropped_reg;
        end
        if (emit)
        begin
            merged_value_reg <= take_first ? a_data_reg : b_data_reg;
            last_reg         <= is_last;
            desc_out_reg     <= desc_reg;
            ovf_out_reg      <= ovf_reg;
        end
    end

    assign result_valid     = result_valid_reg;
    assign merged_value     = merged_value_reg;
    assign last_of_run      = last_reg;
    assign descending_order = desc_out_reg;
    assign overflow_seen    = ovf_out_reg;
    assign busy             = (state_reg != BK_IDLE);

endmodule

/* rtl/core/sorted_list_merge_top.sv */
// Top level of the sorted list merge block: front stage, command queue, back end.
//
// Item channel (item_valid / item_stall, mode, element): mode 0 appends element to
// the first list, mode 1 to the second list, mode 2 merges both lists and emits the
// run, mode 3 is taken and ignored. Result channel (result_valid / result_stall)
// carries merged_value, last_of_run, descending_order and overflow_seen per element.
// Throughput: one append per cycle while no merge runs; a merge of N elements
// emits one result per cycle while the receiver does not stall, set by the merge
// sequencer's single compare-and-select step and the one read port of each list
// store. The first result of a merge passes the front register, the queue and the
// back end before it leaves the output register. Items that arrive during a merge
// wait in the 4-entry queue and the front register; item_stall rises once both are
// full. A merge of two empty lists emits nothing and only clears the drop flag.
// While result_stall is high and a result is pending, the output register holds
// it and the merge sequencer pauses. Reset clears the list counts, the drop flag,
// the queue and all valid flags; list contents are not cleared and need not be.
module sorted_list_merge_top
    import slm_pkg::*;
#(
    parameter int LIST_DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [1:0]               mode,
    input  logic signed [ELEM_W-1:0] element,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [ELEM_W-1:0] merged_value,
    output logic                     last_of_run,
    output logic                     descending_order,
    output logic                     overflow_seen
);

    logic      cmd_valid;
    cmd_t      cmd;
    logic      cmd_full;
    cmd_head_t head;
    logic      pop;
    logic      busy;

    // Classifies each transfer and holds it until the queue has room.
    slm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .mode       (mode),
        .element    (element),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_full   (cmd_full)
    );

    // Decouples intake from the merge, which may stall on the result side.
    slm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_valid),
        .push_cmd   (cmd),
        .full       (cmd_full),
        .pop        (pop),
        .head       (head)
    );

    // Holds both lists and runs appends and merges one at a time.
    slm_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .pop              (pop),
        .result_stall     (result_stall),
        .result_valid     (result_valid),
        .merged_value     (merged_value),
        .last_of_run      (last_of_run),
        .descending_order (descending_order),
        .overflow_seen    (overflow_seen),
        .busy             (busy)
    );

    // A pending non-final result means the merge is still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_of_run |-> busy)
        else $error("non-final result while back end idle");

    // No command leaves the queue while a merge is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !busy)
        else $error("queue popped during merge");

    // Direction stays fixed within a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !last_of_run |=>
            !result_valid || (descending_order == $past(descending_order)))
        else $error("direction changed within a run");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the sorted list merge block.
`timescale 1ns / 1ps

module testbench;
    import slm_pkg::*;

    localparam int LIST_DEPTH   = 32;
    localparam int HOLD_CYCLES  = 150;     // long receiver hold-off for the fill-up test
    localparam int DRAIN_CYCLES = 20;      // quiet tail after the last expected result
    localparam int RANDOM_ITEMS = 300;
    localparam int CYCLE_LIMIT  = 300000;

    localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

    // One merged element as it should appear on the result channel.
    typedef struct packed {
        logic signed [ELEM_W-1:0] value;
        logic                     last;
        logic                     desc;
        logic                     ovf;
    } merge_result_t;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     item_valid   = 1'b0;
    logic                     item_stall;
    logic [1:0]               mode         = MODE_APPEND_FIRST;
    logic signed [ELEM_W-1:0] element      = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic signed [ELEM_W-1:0] merged_value;
    logic                     last_of_run;
    logic                     descending_order;
    logic                     overflow_seen;

    // Shadow copy of the block's list state, updated at each accepted input transfer.
    logic signed [ELEM_W-1:0] first_list [LIST_DEPTH];
    logic signed [ELEM_W-1:0] second_list [LIST_DEPTH];
    int                       first_len  = 0;
    int                       second_len = 0;
    logic                     drop_seen  = 1'b0;

    merge_result_t            pending_results [$];

    int                       error_count    = 0;
    int                       cycle_count    = 0;
    int                       items_accepted = 0;

    // Idle controls: the test tasks switch sender and receiver gaps on and off so
    // that some stretches run at full rate on both sides.
    bit                       send_idle_on = 1'b0;
    bit                       recv_idle_on = 1'b0;
    bit                       hold_pending = 1'b0;
    int                       hold_left    = 0;
    int                       stall_left   = 0;

    sorted_list_merge_top #(
        .LIST_DEPTH       (LIST_DEPTH)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .mode             (mode),
        .element          (element),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .merged_value     (merged_value),
        .last_of_run      (last_of_run),
        .descending_order (descending_order),
        .overflow_seen    (overflow_seen)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Gap length: mostly short, now and then long.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Advance the shadow state by one accepted item and queue the merge output.
    function automatic void apply_item(input mode_t m, input logic signed [ELEM_W-1:0] e);
        int            i;
        int            j;
        int            total;
        logic          desc;
        logic          take_first;
        merge_result_t r;

        case (m)
            MODE_APPEND_FIRST:
            begin
                if (first_len < LIST_DEPTH)
                begin
                    first_list[first_len] = e;
                    first_len++;
                end
                else
                    drop_seen = 1'b1;
            end
            MODE_APPEND_SECOND:
            begin
                if (second_len < LIST_DEPTH)
                begin
                    second_list[second_len] = e;
                    second_len++;
                end
                else
                    drop_seen = 1'b1;
            end
            MODE_MERGE:
            begin
                // Direction from the first list; an empty first list reports ascending,
                // a single element (first == last) runs descending.
                desc  = (first_len > 0) && !(first_list[0] < first_list[first_len-1]);
                total = first_len + second_len;
                i = 0;
                j = 0;
                for (int k = 0; k < total; k++)
                begin
                    if (i < first_len && j < second_len)
                        take_first = desc ? (first_list[i] >= second_list[j])
                                          : (first_list[i] <= second_list[j]);
                    else
                        take_first = (i < first_len);
                    if (take_first)
                    begin
                        r.value = first_list[i];
                        i++;
                    end
                    else
                    begin
                        r.value = second_list[j];
                        j++;
                    end
                    r.last = (k + 1 == total);
                    r.desc = desc;
                    r.ovf  = drop_seen;
                    pending_results.push_back(r);
                end
                first_len  = 0;
                second_len = 0;
                drop_seen  = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // Send one item: optional idle gap, then hold valid until the transfer.
    // Valid stays high between back-to-back items, so it is never dropped and
    // raised in the same time step.
    task automatic send_item(input mode_t m, input logic signed [ELEM_W-1:0] e);
        int gap;

        if (send_idle_on && $urandom_range(0, 2) == 0)
        begin
            gap = pick_gap();
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        mode       <= m;
        element    <= e;
        do
            @(posedge clk);
        while (item_stall);
        apply_item(m, e);
        items_accepted++;
    endtask

    // Receiver side: random stalls, plus a long hold-off counted here when a test
    // asks for one.
    always @(posedge clk)
    begin
        if (hold_pending)
        begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (recv_idle_on && $urandom_range(0, 3) == 0)
        begin
            stall_left = pick_gap() - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Result checker: every result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        merge_result_t want;
        merge_result_t got;

        if (rst_n && result_valid && !result_stall)
        begin
            got = {merged_value, last_of_run, descending_order, overflow_seen};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d last=%0b desc=%0b ovf=%0b",
                         $time, got.value, got.last, got.desc, got.ovf);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected value=%0d last=%0b desc=%0b ovf=%0b",
                             $time, want.value, want.last, want.desc, want.ovf);
                    $display("%0t:          actual   value=%0d last=%0b desc=%0b ovf=%0b",
                             $time, got.value, got.last, got.desc, got.ovf);
                    error_count++;
                end
            end
        end
    end

    // Merge of two empty lists gives nothing, the unused mode is dropped, and an
    // empty first list just copies the second in ascending report.
    task automatic check_empty_and_unused();
        send_item(MODE_MERGE, $urandom);
        send_item(MODE_UNUSED, $urandom);
        send_item(MODE_APPEND_SECOND, ELEM_MIN);
        send_item(MODE_APPEND_SECOND, '0);
        send_item(MODE_APPEND_SECOND, ELEM_MAX);
        send_item(MODE_MERGE, '0);
    endtask

    // One element in the first list runs descending; tie goes to the first list.
    task automatic check_single_first();
        send_item(MODE_APPEND_FIRST, 5);
        send_item(MODE_APPEND_SECOND, 7);
        send_item(MODE_APPEND_SECOND, 5);
        send_item(MODE_APPEND_SECOND, 3);
        send_item(MODE_MERGE, '1);
    endtask

    // Ascending merge with ties at both extremes and in the middle.
    task automatic check_ascending_ties();
        send_item(MODE_APPEND_FIRST, ELEM_MIN);
        send_item(MODE_APPEND_SECOND, ELEM_MIN);
        send_item(MODE_APPEND_FIRST, -1);
        send_item(MODE_APPEND_SECOND, 5);
        send_item(MODE_APPEND_FIRST, 5);
        send_item(MODE_APPEND_SECOND, ELEM_MAX);
        send_item(MODE_APPEND_FIRST, ELEM_MAX);
        send_item(MODE_MERGE, '0);
    endtask

    // Descending merge across the full signed range.
    task automatic check_descending();
        send_item(MODE_APPEND_FIRST, ELEM_MAX);
        send_item(MODE_APPEND_FIRST, '0);
        send_item(MODE_APPEND_FIRST, ELEM_MIN);
        send_item(MODE_APPEND_SECOND, ELEM_MAX);
        send_item(MODE_APPEND_SECOND, -1);
        send_item(MODE_APPEND_SECOND, ELEM_MIN);
        send_item(MODE_MERGE, '0);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering items
    // at full rate: the queue behind the merge fills and item_stall must rise.
    task automatic check_full_backpressure();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            send_item(MODE_APPEND_FIRST, k * 3);
            send_item(MODE_APPEND_SECOND, k * 2);
        end
        hold_pending = 1'b1;
        send_item(MODE_MERGE, '0);
        for (int k = 0; k < 6; k++)
        begin
            send_item(MODE_APPEND_FIRST, 100 - k);
            send_item(MODE_APPEND_SECOND, 90 - k * 4);
        end
        send_item(MODE_MERGE, '0);
    endtask

    // Small sizes mostly; now and then past the list depth to force drops.
    function automatic int pick_length();
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(30, 36);
        return $urandom_range(0, 6);
    endfunction

    function automatic logic signed [ELEM_W-1:0] pick_element(input bit narrow);
        case ($urandom_range(0, 15))
            0:       return ELEM_MIN;
            1:       return ELEM_MAX;
            default: return narrow ? int'($urandom_range(0, 8)) - 4 : $urandom;
        endcase
    endfunction

    // Random runs: mostly pre-sorted lists in either direction with interleaved
    // appends, some unsorted lists, stray unused-mode items and skipped merges.
    task automatic check_random_runs();
        logic signed [ELEM_W-1:0] list_a [$];
        logic signed [ELEM_W-1:0] list_b [$];
        int                       ia;
        int                       ib;
        int                       start_count;
        bit                       descend;
        bit                       narrow;
        bit                       sorted_ok;

        start_count = items_accepted;
        while (items_accepted - start_count < RANDOM_ITEMS)
        begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            descend   = $urandom_range(0, 1);
            narrow    = $urandom_range(0, 1);
            sorted_ok = ($urandom_range(0, 9) != 0);
            list_a.delete();
            list_b.delete();
            repeat (pick_length()) list_a.push_back(pick_element(narrow));
            repeat (pick_length()) list_b.push_back(pick_element(narrow));
            if (sorted_ok)
            begin
                if (descend)
                begin
                    list_a.rsort();
                    list_b.rsort();
                end
                else
                begin
                    list_a.sort();
                    list_b.sort();
                end
            end
            ia = 0;
            ib = 0;
            while (ia < list_a.size() || ib < list_b.size())
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item(MODE_UNUSED, $urandom);
                if (ia < list_a.size() && (ib >= list_b.size() || $urandom_range(0, 1)))
                begin
                    send_item(MODE_APPEND_FIRST, list_a[ia]);
                    ia++;
                end
                else
                begin
                    send_item(MODE_APPEND_SECOND, list_b[ib]);
                    ib++;
                end
            end
            // Occasionally skip the merge so lists carry over into the next run.
            if ($urandom_range(0, 14) != 0)
                send_item(MODE_MERGE, $urandom);
        end
        send_item(MODE_MERGE, $urandom);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_empty_and_unused();
        check_single_first();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        check_ascending_ties();
        check_descending();
        check_full_backpressure();
        check_random_runs();

        // Drain: no more stimulus, receiver runs free, then a short tail to catch
        // any stray result.
        item_valid   <= 1'b0;
        recv_idle_on = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/core/slm_pkg.sv
rtl/core/slm_front.sv
rtl/core/slm_queue.sv
rtl/core/slm_back.sv
rtl/core/sorted_list_merge_top.sv
test/testbench.sv
